/* src/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell, sorted_priority_queue and the bench.
`default_nettype none
package spq_pkg;

    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 5;
    localparam int DEPTH_DEF = 16;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // what one cell shows its neighbors
    typedef struct packed {
        logic                     occ;   // cell holds a value
        logic                     gt;    // held value goes after the pushed value
        logic signed [DATA_W-1:0] data;
    } t_link;

endpackage
`default_nettype wire

/* src/spq_cell.sv */
// One slot of the sorted chain: holds a value and its occupied flag.
// Depends on spq_pkg for t_link and DATA_W.
`default_nettype none
module spq_cell (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_push,
    input  wire logic                             i_pop,
    input  wire logic signed [spq_pkg::DATA_W-1:0] i_value,
    input  wire spq_pkg::t_link                   i_left,
    input  wire spq_pkg::t_link                   i_right,
    output spq_pkg::t_link                        o_link,
    output logic signed [spq_pkg::DATA_W-1:0]     o_next_data
);
    import spq_pkg::*;

    logic                     r_occ;
    logic signed [DATA_W-1:0] r_data;
    logic                     n_occ;
    logic signed [DATA_W-1:0] n_data;
    logic                     gt;

    // an empty slot counts as "after" so the value lands in the first free slot
    assign gt = !r_occ || (r_data > i_value);

    // push and pop never come together; with neither, hold the slot
    always_comb begin
        n_occ  = r_occ;
        n_data = r_data;
        if (i_push) begin
            n_occ = r_occ | i_left.occ;
            if (i_left.gt) begin
                n_data = i_left.data;
            end else if (gt) begin
                n_data = i_value;
            end
        end else if (i_pop) begin
            n_occ  = i_right.occ;
            n_data = i_right.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_link      = '{occ: r_occ, gt: gt, data: r_data};
    assign o_next_data = n_data;

endmodule
`default_nettype wire

/* src/sorted_priority_queue.sv */
// Top level of the sorted priority queue: a chain of spq_cell slots plus
// count, largest-value tracking and the result register. Depends on spq_pkg.
//
// A bounded priority queue of signed 32-bit values kept in ascending order in
// a chain of DEPTH cells; every cell compares the pushed value against its own
// and shifts with its neighbor in the same cycle. A transaction is taken when
// start is high and busy is low; busy never rises, so one push or pop is taken
// every clock cycle. Its result appears on the o_ ports one cycle later for
// exactly one cycle, marked by o_valid, and must be captured then: there is no
// way to hold it off. A push to a full queue or a pop from an empty one changes
// nothing and reports o_ok low. Equal values keep their arrival order.
`default_nettype none
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_op,
    input  wire logic signed [spq_pkg::DATA_W-1:0] i_value,
    output logic                                   o_valid,
    output logic                                   o_ok,
    output logic signed [spq_pkg::DATA_W-1:0]      o_smallest,
    output logic signed [spq_pkg::DATA_W-1:0]      o_largest,
    output logic [spq_pkg::COUNT_W-1:0]            o_count,
    output logic                                   o_is_empty
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    t_link                     links [DEPTH];
    logic signed [DATA_W-1:0]  next0 [DEPTH];
    logic                      accept;
    logic                      full;
    logic                      empty;
    logic                      do_push;
    logic                      do_pop;

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic signed [DATA_W-1:0]  r_largest;
    logic signed [DATA_W-1:0]  n_largest;
    logic [CNT_W+COUNT_W-1:0]  count_ext;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign full    = links[DEPTH-1].occ;
    assign empty   = !links[0].occ;
    assign do_push = accept && (i_op == OP_PUSH) && !full;
    assign do_pop  = accept && (i_op == OP_POP) && !empty;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_link left_l;
            t_link right_l;
            if (g == 0) begin : g_head
                assign left_l = '{occ: 1'b1, gt: 1'b0, data: '0};
            end else begin : g_mid_l
                assign left_l = links[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign right_l = '{occ: 1'b0, gt: 1'b1, data: '0};
            end else begin : g_mid_r
                assign right_l = links[g+1];
            end
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_push      (do_push),
                .i_pop       (do_pop),
                .i_value     (i_value),
                .i_left      (left_l),
                .i_right     (right_l),
                .o_link      (links[g]),
                .o_next_data (next0[g])
            );
        end
    endgenerate

    always_comb begin
        n_count   = r_count;
        n_largest = r_largest;
        if (do_push) begin
            n_count = r_count + CNT_W'(1);
            if (empty || (i_value >= r_largest)) begin
                n_largest = i_value;
            end
        end else if (do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign count_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            o_valid   <= 1'b0;
            o_ok      <= 1'b0;
            o_count   <= '0;
            o_is_empty<= 1'b1;
        end else begin
            r_count    <= n_count;
            o_valid    <= accept;
            if (accept) begin
                o_ok       <= do_push || do_pop;
                o_count    <= count_ext[COUNT_W-1:0];
                o_is_empty <= (n_count == '0);
            end
        end
    end

    // payload registers: largest tracker and result values
    always_ff @(posedge i_clk) begin
        r_largest <= n_largest;
        if (accept) begin
            if (n_count == '0) begin
                o_smallest <= '0;
                o_largest  <= '0;
            end else begin
                o_smallest <= next0[0];
                o_largest  <= n_largest;
            end
        end
    end

endmodule
`default_nettype wire

/* verif/sorted_priority_queue_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sorted_priority_queue: a directed push/pop table, then random
// traffic, each result checked against a typed row or the in-bench sorted-list predictor.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module sorted_priority_queue_test;
    import spq_pkg::*;

    localparam int QDEPTH = DEPTH_DEF;
    localparam logic signed [DATA_W-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VMIN = 32'sh8000_0000;
    localparam int RAND_ITEMS = 1200;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] smallest;
        logic signed [DATA_W-1:0] largest;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
    } t_qresult;

    typedef struct {
        logic                     op;
        logic signed [DATA_W-1:0] value;
        bit                       typed;
        t_qresult                 res;
    } t_dir_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     i_op = OP_PUSH;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     busy;
    logic                     o_valid;
    logic                     o_ok;
    logic signed [DATA_W-1:0] o_smallest;
    logic signed [DATA_W-1:0] o_largest;
    logic [COUNT_W-1:0]       o_count;
    logic                     o_is_empty;

    logic signed [DATA_W-1:0] held_vals [QDEPTH];
    int                       held_count = 0;
    t_qresult                 pending_results [$];
    t_dir_row                 dir_rows [$];
    int                       mismatch_count = 0;

    sorted_priority_queue u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_op       (i_op),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_ok       (o_ok),
        .o_smallest (o_smallest),
        .o_largest  (o_largest),
        .o_count    (o_count),
        .o_is_empty (o_is_empty)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one push or pop to the sorted list and return what the queue reports.
    function automatic t_qresult apply_queue_op(input logic op,
                                                input logic signed [DATA_W-1:0] v);
        t_qresult r;
        int       pos;
        r = '0;
        if (op == OP_PUSH) begin
            if (held_count < QDEPTH) begin
                // first entry strictly greater; equal values stay ahead of the new one
                pos = held_count;
                for (int i = held_count - 1; i >= 0; i--) begin
                    if (held_vals[i] > v) pos = i;
                end
                for (int i = held_count; i > pos; i--) held_vals[i] = held_vals[i-1];
                held_vals[pos] = v;
                held_count++;
                r.ok = 1'b1;
            end
        end else if (held_count > 0) begin
            for (int i = 1; i < held_count; i++) held_vals[i-1] = held_vals[i];
            held_count--;
            r.ok = 1'b1;
        end
        if (held_count == 0) begin
            r.is_empty = 1'b1;
        end else begin
            r.smallest = held_vals[0];
            r.largest  = held_vals[held_count-1];
        end
        r.count = COUNT_W'(held_count);
        return r;
    endfunction

    function automatic t_dir_row dir_row(input logic op, input logic signed [DATA_W-1:0] v,
                                         input bit typed, input logic ok,
                                         input logic signed [DATA_W-1:0] smallest,
                                         input logic signed [DATA_W-1:0] largest,
                                         input int count, input logic is_empty);
        t_dir_row row;
        row.op             = op;
        row.value          = v;
        row.typed          = typed;
        row.res.ok         = ok;
        row.res.smallest   = smallest;
        row.res.largest    = largest;
        row.res.count      = COUNT_W'(count);
        row.res.is_empty   = is_empty;
        return row;
    endfunction

    // Drive one transaction after an optional gap; hold it until busy is low.
    task automatic issue_txn(input logic op, input logic signed [DATA_W-1:0] v,
                             input int gap, input bit typed, input t_qresult typed_res);
        t_qresult predicted;
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start   <= 1'b1;
        i_op    <= op;
        i_value <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = apply_queue_op(op, v);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_qresult want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual ok=%0b count=%0d",
                         $time, o_ok, o_count);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("ok", want.ok, o_ok);
                check_field("smallest", longint'(want.smallest), longint'(o_smallest));
                check_field("largest", longint'(want.largest), longint'(o_largest));
                check_field("count", want.count, o_count);
                check_field("is_empty", want.is_empty, o_is_empty);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int                       idle_pct;
        int                       push_pct;
        int                       gap;
        int                       pick;
        logic                     op;
        logic signed [DATA_W-1:0] v;

        // empty pop, extremes, equal values, fill to the top, full push, a few pops
        dir_rows.push_back(dir_row(OP_POP,  0,    1, 1'b0, 0,    0,    0, 1'b1));
        dir_rows.push_back(dir_row(OP_PUSH, VMAX, 1, 1'b1, VMAX, VMAX, 1, 1'b0));
        dir_rows.push_back(dir_row(OP_PUSH, VMIN, 1, 1'b1, VMIN, VMAX, 2, 1'b0));
        dir_rows.push_back(dir_row(OP_PUSH, 0,    0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(dir_row(OP_PUSH, 0,    0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(dir_row(OP_PUSH, -1,   0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(dir_row(OP_PUSH, VMAX, 0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(dir_row(OP_PUSH, VMIN, 0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(dir_row(OP_PUSH, 1,    0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(dir_row(OP_PUSH, 32'sh5555_5555, 0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(dir_row(OP_PUSH, 32'shAAAA_AAAA, 0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(dir_row(OP_PUSH, 7,    0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(dir_row(OP_PUSH, 7,    0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(dir_row(OP_PUSH, -7,   0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(dir_row(OP_PUSH, 32'sh1234_5678, 0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(dir_row(OP_PUSH, -100, 0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(dir_row(OP_PUSH, 42,   0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(dir_row(OP_PUSH, 3,    1, 1'b0, VMIN, VMAX, QDEPTH, 1'b0));
        dir_rows.push_back(dir_row(OP_POP,  -1,   0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(dir_row(OP_POP,  0,    0, 1'b0, 0, 0, 0, 1'b0));
        dir_rows.push_back(dir_row(OP_POP,  VMAX, 0, 1'b0, 0, 0, 0, 1'b0));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            issue_txn(dir_rows[k].op, dir_rows[k].value, 0, dir_rows[k].typed,
                      dir_rows[k].res);

        idle_pct = 0;
        push_pct = 50;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            case (n / (RAND_ITEMS / 4))
                0:       idle_pct = 0;
                1:       idle_pct = 60;
                2:       idle_pct = 0;
                default: idle_pct = 34;
            endcase
            // swing between filling and draining so full and empty both get hit
            if (n % 50 == 0) begin
                case ((n / 50) % 4)
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    2:       push_pct = 50;
                    default: push_pct = 60;
                endcase
            end
            op   = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            pick = $urandom_range(0, 9);
            if (pick == 0)
                v = VMIN;
            else if (pick == 1)
                v = VMAX;
            else if (pick <= 4)
                v = $signed($urandom_range(0, 8)) - 4;
            else
                v = $urandom;
            gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 3) : 0;
            issue_txn(op, v, gap, 1'b0, '0);
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
